// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers, compiled out under SYNTH.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPL(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rstn, prop, msg)
`define ASSERT_NR(label, clk, prop, msg)
`endif
`endif

// ===== rtl/pte_pkg.sv =====
// ----------------------------------------------------------------------------
// Task table package
// Types and codes shared by the task table engine.
// ----------------------------------------------------------------------------
`default_nettype none
package pte_pkg;
  localparam int unsigned Slots   = 64;
  localparam int unsigned SlotW   = $clog2(Slots);
  localparam logic [15:0] PidLast = 16'd65534;

  typedef enum logic [3:0] {
    CMD_CREATE = 4'd0, CMD_TERM = 4'd1, CMD_EXIT = 4'd2, CMD_SET_STATE = 4'd3,
    CMD_SLEEP = 4'd4, CMD_WAKE = 4'd5, CMD_SET_CUR = 4'd6, CMD_LOOKUP = 4'd7,
    CMD_COUNT_ST = 4'd8, CMD_COUNT_ACT = 4'd9
  } cmd_e;

  localparam logic [2:0] StUnused   = 3'd0;
  localparam logic [2:0] StReady    = 3'd1;
  localparam logic [2:0] StRunning  = 3'd2;
  localparam logic [2:0] StSleeping = 3'd4;
  localparam logic [2:0] StZombie   = 3'd5;

  localparam logic [1:0] StatOk      = 2'd0;
  localparam logic [1:0] StatMissing = 2'd1;
  localparam logic [1:0] StatRefused = 2'd2;

  localparam logic [1:0] RegRealtime = 2'd0;
  localparam logic [1:0] RegHigh     = 2'd1;
  localparam logic [1:0] RegNormal   = 2'd2;
  localparam logic [1:0] RegLow      = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_TERM_SWEEP, S_LOOKUP_RD, S_DONE
  } state_e;

  typedef struct packed {
    logic [3:0]  cmd;
    logic [15:0] target_pid;
    logic [2:0]  priority_req;
    logic [2:0]  new_state;
    logic signed [31:0] exit_value;
    logic [63:0] tick;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] result_pid;
    logic [2:0]  result_state;
    logic [15:0] result_parent;
    logic [2:0]  result_priority;
    logic [7:0]  result_slice;
    logic signed [31:0] result_exit;
    logic [6:0]  result_count;
  } out_word_t;

  typedef struct packed {
    logic [15:0] pid;
    logic        pid_ok;
    logic [2:0]  state;
    logic [15:0] parent;
    logic [2:0]  prio;
    logic [7:0]  dslice;
    logic [7:0]  slice;
    logic [31:0] exit_val;
    logic [63:0] wake;
  } entry_t;

  typedef struct packed {
    logic             we;
    logic [SlotW-1:0] addr;
    entry_t           data;
  } tbl_wr_t;
endpackage
`default_nettype wire

// ===== rtl/pte_table.sv =====
// ----------------------------------------------------------------------------
// Task table storage
// Slot memory with one write port and one registered read port; reset clears
// the valid bits, and slot 0 then reads as the kernel entry until written.
// ----------------------------------------------------------------------------
`default_nettype none
module pte_table (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire pte_pkg::tbl_wr_t       wr_i,
  input  wire logic [pte_pkg::SlotW-1:0] rd_addr_i,
  output pte_pkg::entry_t             rd_data_o
);
  pte_pkg::entry_t mem_q [pte_pkg::Slots];
  logic [pte_pkg::Slots-1:0] vld_q;
  pte_pkg::entry_t rd_q;
  logic rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    rd_q <= mem_q[rd_addr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_i.we) begin
        vld_q[wr_i.addr] <= 1'b1;
      end
      rd_vld_q <= vld_q[rd_addr_i];
    end
  end

  logic [pte_pkg::SlotW-1:0] rd_addr_q;
  always_ff @(posedge clk_i) begin
    rd_addr_q <= rd_addr_i;
  end

  always_comb begin
    rd_data_o = '0;
    if (rd_vld_q) begin
      rd_data_o = rd_q;
    end else if (rd_addr_q == '0) begin
      rd_data_o.pid_ok = 1'b1;
      rd_data_o.state  = pte_pkg::StRunning;
      rd_data_o.prio   = 3'd3;
      rd_data_o.dslice = 8'd20;
      rd_data_o.slice  = 8'd20;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/pte_ctrl.sv =====
// ----------------------------------------------------------------------------
// Task table sequencer
// Walks the slots one a cycle through the shared compare unit (wake updates
// slots as it goes), then writes back where needed and forms the result word.
// ----------------------------------------------------------------------------
`default_nettype none
module pte_ctrl (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire pte_pkg::in_word_t      in_data_i,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output pte_pkg::out_word_t          out_data_o,
  input  wire logic [7:0]             slice_rt_i,
  input  wire logic [7:0]             slice_hi_i,
  input  wire logic [7:0]             slice_no_i,
  input  wire logic [7:0]             slice_lo_i,
  output pte_pkg::tbl_wr_t            wr_o,
  output logic [pte_pkg::SlotW-1:0]   rd_addr_o,
  input  wire pte_pkg::entry_t        rd_data_i
);
  localparam int unsigned SlotW = pte_pkg::SlotW;
  localparam int unsigned IdxW  = SlotW + 1;

  pte_pkg::state_e state_q, state_d;
  pte_pkg::in_word_t req_q, req_d;
  pte_pkg::out_word_t res_q, res_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [SlotW-1:0] hit_q, hit_d;
  logic            found_q, found_d;
  logic [15:0]     key_q, key_d;
  logic [7:0]      cnt_q, cnt_d;
  logic [15:0]     pid_ctr_q, pid_ctr_d;
  logic [15:0]     run_pid_q, run_pid_d;
  logic            run_vld_q, run_vld_d;
  logic            outv_q, outv_d;

  logic [SlotW-1:0] cur;
  logic match_pid, match_live;
  pte_pkg::entry_t e;
  logic [7:0] slice_sel;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= pte_pkg::S_IDLE;
      idx_q     <= '0;
      found_q   <= 1'b0;
      pid_ctr_q <= 16'd1;
      run_pid_q <= '0;
      run_vld_q <= 1'b1;
      outv_q    <= 1'b0;
      cnt_q     <= '0;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      found_q   <= found_d;
      pid_ctr_q <= pid_ctr_d;
      run_pid_q <= run_pid_d;
      run_vld_q <= run_vld_d;
      outv_q    <= outv_d;
      cnt_q     <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    res_q <= res_d;
    hit_q <= hit_d;
    key_q <= key_d;
  end

  assign cur = idx_q[SlotW-1:0] - SlotW'(1);
  assign e   = rd_data_i;
  assign match_pid  = e.pid_ok && e.pid == key_q;
  assign match_live = match_pid && e.state != pte_pkg::StUnused;

  always_comb begin
    unique case (req_q.priority_req)
      3'd0:    slice_sel = slice_rt_i;
      3'd1:    slice_sel = slice_hi_i;
      3'd3:    slice_sel = slice_lo_i;
      default: slice_sel = slice_no_i;
    endcase
  end

  assign in_stall_o  = state_q != pte_pkg::S_IDLE;
  assign out_valid_o = outv_q;
  assign out_data_o  = res_q;

  always_comb begin
    state_d = state_q; req_d = req_q; res_d = res_q; idx_d = idx_q;
    hit_d = hit_q; found_d = found_q; key_d = key_q;
    cnt_d = cnt_q; pid_ctr_d = pid_ctr_q; run_pid_d = run_pid_q;
    run_vld_d = run_vld_q; outv_d = outv_q;
    wr_o = '0; rd_addr_o = idx_q[SlotW-1:0];
    unique case (state_q)
      pte_pkg::S_IDLE: begin
        if (in_valid_i) begin
          req_d = in_data_i; res_d = '0; idx_d = '0; found_d = 1'b0;
          cnt_d = '0; key_d = in_data_i.target_pid;
          rd_addr_o = '0;
          priority case (pte_pkg::cmd_e'(in_data_i.cmd))
            pte_pkg::CMD_CREATE, pte_pkg::CMD_SET_STATE, pte_pkg::CMD_SLEEP,
            pte_pkg::CMD_LOOKUP, pte_pkg::CMD_WAKE, pte_pkg::CMD_COUNT_ST,
            pte_pkg::CMD_COUNT_ACT: begin
              state_d = pte_pkg::S_SCAN; idx_d = IdxW'(1);
            end
            pte_pkg::CMD_TERM: begin
              if (in_data_i.target_pid == '0) begin
                res_d.status = pte_pkg::StatRefused; state_d = pte_pkg::S_DONE;
              end else begin
                state_d = pte_pkg::S_SCAN; idx_d = IdxW'(1);
              end
            end
            pte_pkg::CMD_EXIT: begin
              if (!run_vld_q || run_pid_q == '0) begin
                res_d.status = pte_pkg::StatRefused; state_d = pte_pkg::S_DONE;
              end else begin
                key_d = run_pid_q;
                state_d = pte_pkg::S_SCAN; idx_d = IdxW'(1);
              end
            end
            pte_pkg::CMD_SET_CUR: begin
              run_pid_d = in_data_i.target_pid; run_vld_d = 1'b1;
              state_d = pte_pkg::S_DONE;
            end
            default: begin
              res_d.status = pte_pkg::StatRefused; state_d = pte_pkg::S_DONE;
            end
          endcase
        end
      end
      pte_pkg::S_SCAN: begin
        // slot cur data is on rd_data_i; idx_q is the next address
        idx_d = idx_q + IdxW'(1);
        unique case (pte_pkg::cmd_e'(req_q.cmd))
          pte_pkg::CMD_CREATE: begin
            if (!found_q && e.state == pte_pkg::StUnused) begin
              found_d = 1'b1; hit_d = cur;
            end
          end
          pte_pkg::CMD_TERM, pte_pkg::CMD_EXIT, pte_pkg::CMD_LOOKUP: begin
            if (!found_q && match_live) begin
              found_d = 1'b1; hit_d = cur;
            end
          end
          pte_pkg::CMD_SET_STATE, pte_pkg::CMD_SLEEP: begin
            if (!found_q && match_pid) begin
              found_d = 1'b1; hit_d = cur;
            end
          end
          pte_pkg::CMD_WAKE: begin
            if (e.state == pte_pkg::StSleeping && req_q.tick >= e.wake) begin
              wr_o.we = 1'b1; wr_o.addr = cur; wr_o.data = e;
              wr_o.data.state = pte_pkg::StReady; wr_o.data.slice = e.dslice;
              cnt_d = cnt_q + 8'd1;
            end
          end
          pte_pkg::CMD_COUNT_ST: begin
            if (e.state == req_q.new_state) cnt_d = cnt_q + 8'd1;
          end
          default: begin
            if (e.state != pte_pkg::StUnused) cnt_d = cnt_q + 8'd1;
          end
        endcase
        if (idx_q == IdxW'(pte_pkg::Slots)) begin
          state_d = pte_pkg::S_DONE;
          res_d.result_count = (cnt_d > 8'd127) ? 7'd127 : cnt_d[6:0];
          if (req_q.cmd == pte_pkg::CMD_WAKE || req_q.cmd == pte_pkg::CMD_COUNT_ST ||
              req_q.cmd == pte_pkg::CMD_COUNT_ACT) begin
            state_d = pte_pkg::S_DONE;
          end else begin
            res_d.result_count = '0;
            if (!found_d) begin
              res_d.status = pte_pkg::StatMissing;
            end else begin
              rd_addr_o = hit_d;
              state_d = pte_pkg::S_LOOKUP_RD;
            end
          end
        end
      end
      pte_pkg::S_LOOKUP_RD: begin
        // hit entry now on rd_data_i
        wr_o.addr = hit_q; wr_o.data = e;
        state_d = pte_pkg::S_DONE;
        unique case (pte_pkg::cmd_e'(req_q.cmd))
          pte_pkg::CMD_CREATE: begin
            wr_o.we = 1'b1;
            wr_o.data.pid = pid_ctr_q; wr_o.data.pid_ok = 1'b1;
            wr_o.data.parent = run_vld_q ? run_pid_q : 16'd0;
            wr_o.data.state = pte_pkg::StReady; wr_o.data.prio = req_q.priority_req;
            wr_o.data.exit_val = '0; wr_o.data.wake = '0;
            wr_o.data.dslice = slice_sel; wr_o.data.slice = slice_sel;
            res_d.result_pid = pid_ctr_q;
            pid_ctr_d = (pid_ctr_q >= pte_pkg::PidLast) ? 16'd1 : pid_ctr_q + 16'd1;
          end
          pte_pkg::CMD_SET_STATE: begin
            wr_o.we = 1'b1; wr_o.data.state = req_q.new_state;
          end
          pte_pkg::CMD_SLEEP: begin
            wr_o.we = 1'b1; wr_o.data.state = pte_pkg::StSleeping;
            wr_o.data.wake = req_q.tick;
          end
          pte_pkg::CMD_LOOKUP: begin
            res_d.result_pid = e.pid; res_d.result_state = e.state;
            res_d.result_parent = e.parent; res_d.result_priority = e.prio;
            res_d.result_slice = e.slice; res_d.result_exit = e.exit_val;
          end
          default: begin
            // terminate or exit: mark zombie, then sweep children
            wr_o.we = 1'b1; wr_o.data.state = pte_pkg::StZombie;
            wr_o.data.exit_val = req_q.exit_value;
            if (e.parent == key_q) wr_o.data.parent = '0;
            idx_d = IdxW'(1); rd_addr_o = '0;
            state_d = pte_pkg::S_TERM_SWEEP;
          end
        endcase
      end
      pte_pkg::S_TERM_SWEEP: begin
        idx_d = idx_q + IdxW'(1);
        if (cur != hit_q && e.parent == key_q && e.state != pte_pkg::StUnused) begin
          wr_o.we = 1'b1; wr_o.addr = cur; wr_o.data = e; wr_o.data.parent = '0;
        end
        if (idx_q == IdxW'(pte_pkg::Slots)) state_d = pte_pkg::S_DONE;
      end
      default: begin
        if (!outv_q) begin
          outv_d = 1'b1;
        end else if (!out_stall_i) begin
          outv_d = 1'b0; state_d = pte_pkg::S_IDLE;
        end
      end
    endcase
  end
endmodule
`default_nettype wire

// ===== rtl/process_table_engine_top.sv =====
// ----------------------------------------------------------------------------
// Task table engine, top level
// One command word in, one result word out.
// ----------------------------------------------------------------------------
// From one accepted command word to the next: wake, both counts and any
// search that misses make one plain pass over the 64 slots through the
// single table read port; create, set state, sleep and lookup then read back
// or update the hit slot; terminate and exit current update it too and then
// make a second 64-slot pass that reparents the children; set current and
// refused commands skip the pass. The result word goes valid before the
// earliest next acceptance, and output stall delays that acceptance. No new
// word is taken until the result leaves.
`default_nettype none
`include "assert_macros.svh"
module process_table_engine_top (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire pte_pkg::in_word_t  in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output pte_pkg::out_word_t      out_data_o,
  input  wire logic               cfg_we_i,
  input  wire logic [1:0]         cfg_index_i,
  input  wire logic [7:0]         cfg_data_i
);
  logic [7:0] rt_q, hi_q, no_q, lo_q;
  pte_pkg::tbl_wr_t wr;
  logic [pte_pkg::SlotW-1:0] rd_addr;
  pte_pkg::entry_t rd_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rt_q <= 8'd2; hi_q <= 8'd5; no_q <= 8'd10; lo_q <= 8'd20;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        pte_pkg::RegRealtime: rt_q <= cfg_data_i;
        pte_pkg::RegHigh:     hi_q <= cfg_data_i;
        pte_pkg::RegNormal:   no_q <= cfg_data_i;
        default:              lo_q <= cfg_data_i;
      endcase
    end
  end

  pte_table u_table (
    .clk_i, .rst_ni, .wr_i(wr), .rd_addr_i(rd_addr), .rd_data_o(rd_data)
  );

  pte_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o,
    .slice_rt_i(rt_q), .slice_hi_i(hi_q), .slice_no_i(no_q), .slice_lo_i(lo_q),
    .wr_o(wr), .rd_addr_o(rd_addr), .rd_data_i(rd_data)
  );

  `ASSERT_IMPL(a_no_accept_busy, clk_i, rst_ni, out_valid_o |-> in_stall_o,
    "input accepted while result pending")
  `ASSERT_IMPL(a_out_hold, clk_i, rst_ni,
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o),
    "result changed while stalled")
endmodule
`default_nettype wire
